// ----- src/lzsswd_pkg.sv -----
// Shared types, codes and constants of the LZSS window decompressor.
package lzsswd_pkg;

    localparam int DEFAULT_WINDOW_DEPTH = 4096;
    localparam int COUNT_W = 25;
    localparam int CONSUMED_W = 32;
    localparam int TOKEN_INDEX_W = 12;
    localparam int COPY_LEN_W = 5;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 25'h1000000;
    localparam logic [COPY_LEN_W-1:0] COPY_LEN_BIAS = 5'd2;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_TRUNC = 2'd2;
    localparam logic [1:0] KIND_LIMIT = 2'd3;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_ITEM    = 2'd1;
    localparam logic [1:0] PH_CONTROL = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } in_item_t;

    typedef struct packed {
        logic [7:0]            out_byte;
        logic [1:0]            kind;
        logic                  run_last;
        logic [COUNT_W-1:0]    total_out;
        logic [CONSUMED_W-1:0] bytes_consumed;
    } out_item_t;

    typedef struct packed {
        logic       accept;
        logic       hdr_load;
        logic       idx_load;
        logic       copy_load;
        logic       win_read;
        logic       emit_data;
        logic       data_from_win;
        logic       data_last;
        logic       copy_step;
        logic       flag_next;
        logic       stat_set;
        logic [1:0] stat_kind;
        logic       stat_adj;
        logic       emit_stat;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] phase;
        logic       flag0;
        logic       fin;
        logic       src_zero;
        logic       copy_over;
        logic       lit_over;
        logic       copy_last;
        logic       out_free;
    } dp_status_t;

endpackage

// ----- src/lzsswd_ctrl.sv -----
// Controller state machine of the LZSS window decompressor.
module lzsswd_ctrl import lzsswd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t dp_st,
    output dp_cmd_t    dp_cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DECODE  = 3'd1;
    localparam logic [2:0] ST_LIT     = 3'd2;
    localparam logic [2:0] ST_COPY_RD = 3'd3;
    localparam logic [2:0] ST_COPY_WR = 3'd4;
    localparam logic [2:0] ST_STATUS  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        dp_cmd = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    dp_cmd.accept = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (dp_st.phase)
                    PH_HEADER: begin
                        dp_cmd.hdr_load = 1'b1;
                        if (dp_st.fin) begin
                            dp_cmd.stat_set = 1'b1;
                            dp_cmd.stat_kind = KIND_TRUNC;
                            state_next = ST_STATUS;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                    PH_ITEM: begin
                        if (dp_st.flag0) begin
                            state_next = ST_LIT;
                        end else begin
                            dp_cmd.idx_load = 1'b1;
                            if (dp_st.fin) begin
                                dp_cmd.stat_set = 1'b1;
                                dp_cmd.stat_kind = KIND_TRUNC;
                                dp_cmd.stat_adj = 1'b1;
                                state_next = ST_STATUS;
                            end else begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                    PH_CONTROL: begin
                        if (dp_st.src_zero) begin
                            dp_cmd.stat_set = 1'b1;
                            dp_cmd.stat_kind = KIND_END;
                            state_next = ST_STATUS;
                        end else if (dp_st.copy_over) begin
                            dp_cmd.stat_set = 1'b1;
                            dp_cmd.stat_kind = KIND_LIMIT;
                            state_next = ST_STATUS;
                        end else begin
                            dp_cmd.copy_load = 1'b1;
                            state_next = ST_COPY_RD;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_LIT: begin
                if (dp_st.out_free) begin
                    dp_cmd.emit_data = 1'b1;
                    if (dp_st.lit_over) begin
                        dp_cmd.stat_set = 1'b1;
                        dp_cmd.stat_kind = KIND_LIMIT;
                        state_next = ST_STATUS;
                    end else begin
                        dp_cmd.flag_next = 1'b1;
                        if (dp_st.fin) begin
                            dp_cmd.stat_set = 1'b1;
                            dp_cmd.stat_kind = KIND_TRUNC;
                            state_next = ST_STATUS;
                        end else begin
                            dp_cmd.data_last = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_COPY_RD: begin
                dp_cmd.win_read = 1'b1;
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                if (dp_st.out_free) begin
                    dp_cmd.emit_data = 1'b1;
                    dp_cmd.data_from_win = 1'b1;
                    dp_cmd.copy_step = 1'b1;
                    if (dp_st.copy_last) begin
                        dp_cmd.flag_next = 1'b1;
                        if (dp_st.fin) begin
                            dp_cmd.stat_set = 1'b1;
                            dp_cmd.stat_kind = KIND_TRUNC;
                            state_next = ST_STATUS;
                        end else begin
                            dp_cmd.data_last = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end else begin
                        state_next = ST_COPY_RD;
                    end
                end
            end
            ST_STATUS: begin
                if (dp_st.out_free) begin
                    dp_cmd.emit_stat = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/lzsswd_datapath.sv -----
// Datapath of the LZSS window decompressor: parse state, counters, window, output register.
module lzsswd_datapath import lzsswd_pkg::*; #(
    parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  in_item_t           s_item,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    input  dp_cmd_t            dp_cmd,
    output dp_status_t         dp_st,
    input  logic               m_ready,
    output logic               m_valid,
    output out_item_t          m_item
);

    localparam int AW = $clog2(WINDOW_DEPTH);

    logic [7:0] window_mem [WINDOW_DEPTH];

    logic [COUNT_W-1:0]    limit_reg, limit_next;
    logic [1:0]            phase_reg, phase_next;
    logic [7:0]            flag_bits_reg, flag_bits_next;
    logic [3:0]            flags_left_reg, flags_left_next;
    logic [7:0]            index_low_reg, index_low_next;
    logic [COUNT_W-1:0]    ec_reg, ec_next;
    logic [CONSUMED_W-1:0] cc_reg, cc_next;
    logic                  m_valid_reg, m_valid_next;

    logic [7:0]            byte_reg;
    logic                  fin_reg;
    logic [AW-1:0]         src_reg;
    logic [COPY_LEN_W-1:0] cnt_reg;
    logic [1:0]            stat_kind_reg;
    logic                  stat_adj_reg;
    logic [7:0]            win_q_reg;
    logic                  win_hit_reg;
    out_item_t             m_item_reg, m_item_next;

    logic [TOKEN_INDEX_W-1:0] tok_index;
    logic [COPY_LEN_W-1:0]    tok_len;
    logic [COUNT_W-1:0]       ec_inc;
    logic [COUNT_W-1:0]       limit_room;
    logic [3:0]               flags_left_dec;
    logic [7:0]               data_byte;
    logic                     win_hit;

    assign tok_index = {byte_reg[7:4], index_low_reg};
    assign tok_len = {1'b0, byte_reg[3:0]} + COPY_LEN_BIAS;
    assign ec_inc = ec_reg + 25'd1;
    assign limit_room = limit_reg - ec_reg;
    assign flags_left_dec = (flags_left_reg != 4'd0) ? flags_left_reg - 4'd1 : 4'd0;
    assign data_byte = dp_cmd.data_from_win ? (win_hit_reg ? win_q_reg : 8'h00) : byte_reg;
    assign win_hit = (ec_reg >= COUNT_W'(WINDOW_DEPTH))
                     || ((src_reg != '0) && (COUNT_W'(src_reg) <= ec_reg));

    assign dp_st.phase = phase_reg;
    assign dp_st.flag0 = flag_bits_reg[0];
    assign dp_st.fin = fin_reg;
    assign dp_st.src_zero = (tok_index == '0);
    assign dp_st.copy_over = (ec_reg > limit_reg) || (COUNT_W'(tok_len) > limit_room);
    assign dp_st.lit_over = (ec_reg >= limit_reg);
    assign dp_st.copy_last = (cnt_reg == COPY_LEN_W'(1));
    assign dp_st.out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_item = m_item_reg;

    always_comb begin
        limit_next = cfg_wr_en ? cfg_wr_data : limit_reg;
        phase_next = phase_reg;
        flag_bits_next = flag_bits_reg;
        flags_left_next = flags_left_reg;
        index_low_next = index_low_reg;
        ec_next = ec_reg;
        cc_next = cc_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        m_item_next = m_item_reg;

        if (dp_cmd.accept) begin
            cc_next = cc_reg + 32'd1;
        end
        if (dp_cmd.hdr_load) begin
            flag_bits_next = byte_reg;
            flags_left_next = 4'd8;
            phase_next = PH_ITEM;
        end
        if (dp_cmd.idx_load) begin
            index_low_next = byte_reg;
            phase_next = PH_CONTROL;
        end
        if (dp_cmd.emit_data) begin
            ec_next = (&ec_reg) ? ec_reg : ec_inc;
            m_valid_next = 1'b1;
            m_item_next.out_byte = data_byte;
            m_item_next.kind = KIND_DATA;
            m_item_next.run_last = dp_cmd.data_last;
            m_item_next.total_out = '0;
            m_item_next.bytes_consumed = '0;
        end
        if (dp_cmd.flag_next) begin
            flag_bits_next = {1'b0, flag_bits_reg[7:1]};
            flags_left_next = flags_left_dec;
            phase_next = (flags_left_dec == 4'd0) ? PH_HEADER : PH_ITEM;
        end
        if (dp_cmd.emit_stat) begin
            m_valid_next = 1'b1;
            m_item_next.out_byte = 8'h00;
            m_item_next.kind = stat_kind_reg;
            m_item_next.run_last = 1'b1;
            m_item_next.total_out = ec_reg;
            m_item_next.bytes_consumed = cc_reg - CONSUMED_W'(stat_adj_reg);
            phase_next = PH_HEADER;
            flag_bits_next = '0;
            flags_left_next = '0;
            index_low_next = '0;
            ec_next = '0;
            cc_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
            phase_reg <= PH_HEADER;
            flag_bits_reg <= '0;
            flags_left_reg <= '0;
            index_low_reg <= '0;
            ec_reg <= '0;
            cc_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            limit_reg <= limit_next;
            phase_reg <= phase_next;
            flag_bits_reg <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            index_low_reg <= index_low_next;
            ec_reg <= ec_next;
            cc_reg <= cc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
        if (dp_cmd.accept) begin
            byte_reg <= s_item.data_byte;
            fin_reg <= s_item.is_final;
        end
        if (dp_cmd.copy_load) begin
            src_reg <= AW'(tok_index);
            cnt_reg <= tok_len;
        end else if (dp_cmd.copy_step) begin
            src_reg <= src_reg + AW'(1);
            cnt_reg <= cnt_reg - COPY_LEN_W'(1);
        end
        if (dp_cmd.stat_set) begin
            stat_kind_reg <= dp_cmd.stat_kind;
            stat_adj_reg <= dp_cmd.stat_adj;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.win_read) begin
            win_q_reg <= window_mem[src_reg];
            win_hit_reg <= win_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.emit_data) begin
            window_mem[ec_inc[AW-1:0]] <= data_byte;
        end
    end

endmodule

// ----- src/lzsswd_window_decompressor_unit.sv -----
// Top level: LZSS decompressor with a history window, one input byte per transfer.
// Only one input byte is in flight: s_ready is high in the idle state alone, so a byte and all
// output it causes (literal, copied bytes, status) finish before the next byte is taken.
// A copy token reads, then writes, the window for each copied byte, and waits while output is held.
// Reset: synchronous active-low aresetn clears control state and reloads the limit register; the
// window counts as empty through the emitted-byte fill count, with no clearing pass.
module lzss_window_decompressor_unit import lzsswd_pkg::*; #(
    parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_item,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_st;

    lzsswd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .dp_st   (dp_st),
        .dp_cmd  (dp_cmd)
    );

    lzsswd_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_item      (s_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .dp_cmd      (dp_cmd),
        .dp_st       (dp_st),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_item      (m_item)
    );

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for the LZSS window decompressor: table and random streams against a decoder.
module tb import lzsswd_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 5000;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int SETTLE_CYCLES = 10;
    localparam int PLAN_N = 29;
    localparam int PHASE_ITEMS = 46;

    typedef struct packed {
        logic               cfg;
        logic [COUNT_W-1:0] lim;
        logic [7:0]         data;
        logic               fin;
        logic               has_want;
        out_item_t          want;
    } plan_row_t;

    localparam out_item_t NONE = '0;

    localparam plan_row_t PLAN [PLAN_N] = '{
        '{1'b0, 25'd0, 8'h15, 1'b0, 1'b0, NONE},
        '{1'b0, 25'd0, 8'hFF, 1'b0, 1'b1, '{8'hFF, KIND_DATA, 1'b1, 25'd0, 32'd0}},
        '{1'b0, 25'd0, 8'h01, 1'b0, 1'b0, NONE},
        '{1'b0, 25'd0, 8'h0F, 1'b0, 1'b0, NONE},
        '{1'b0, 25'd0, 8'h00, 1'b0, 1'b1, '{8'h00, KIND_DATA, 1'b1, 25'd0, 32'd0}},
        '{1'b0, 25'd0, 8'hFF, 1'b0, 1'b0, NONE},
        '{1'b0, 25'd0, 8'hF0, 1'b0, 1'b0, NONE},
        '{1'b0, 25'd0, 8'h5A, 1'b0, 1'b0, NONE},
        '{1'b0, 25'd0, 8'h00, 1'b0, 1'b0, NONE},
        '{1'b0, 25'd0, 8'h00, 1'b0, 1'b1, '{8'h00, KIND_END, 1'b1, 25'd22, 32'd10}},
        '{1'b0, 25'd0, 8'h00, 1'b1, 1'b1, '{8'h00, KIND_TRUNC, 1'b1, 25'd0, 32'd1}},
        '{1'b0, 25'd0, 8'h01, 1'b0, 1'b0, NONE},
        '{1'b0, 25'd0, 8'h80, 1'b1, 1'b1, '{8'h00, KIND_TRUNC, 1'b1, 25'd1, 32'd2}},
        '{1'b0, 25'd0, 8'h00, 1'b0, 1'b0, NONE},
        '{1'b0, 25'd0, 8'h34, 1'b1, 1'b1, '{8'h00, KIND_TRUNC, 1'b1, 25'd0, 32'd1}},
        '{1'b0, 25'd0, 8'h00, 1'b0, 1'b0, NONE},
        '{1'b0, 25'd0, 8'h01, 1'b0, 1'b0, NONE},
        '{1'b0, 25'd0, 8'h10, 1'b1, 1'b1, '{8'h00, KIND_TRUNC, 1'b1, 25'd2, 32'd3}},
        '{1'b1, 25'd0, 8'h00, 1'b0, 1'b0, NONE},
        '{1'b0, 25'd0, 8'h01, 1'b0, 1'b0, NONE},
        '{1'b0, 25'd0, 8'h12, 1'b0, 1'b1, '{8'h00, KIND_LIMIT, 1'b1, 25'd1, 32'd2}},
        '{1'b0, 25'd0, 8'h00, 1'b0, 1'b0, NONE},
        '{1'b0, 25'd0, 8'h05, 1'b0, 1'b0, NONE},
        '{1'b0, 25'd0, 8'h00, 1'b0, 1'b1, '{8'h00, KIND_LIMIT, 1'b1, 25'd0, 32'd3}},
        '{1'b1, 25'd3, 8'h00, 1'b0, 1'b0, NONE},
        '{1'b0, 25'd0, 8'h02, 1'b0, 1'b0, NONE},
        '{1'b0, 25'd0, 8'h07, 1'b0, 1'b0, NONE},
        '{1'b0, 25'd0, 8'hA1, 1'b0, 1'b0, NONE},
        '{1'b0, 25'd0, 8'hC3, 1'b0, 1'b1, '{8'h00, KIND_LIMIT, 1'b1, 25'd4, 32'd4}}
    };

    localparam logic [COUNT_W-1:0] PHASE_LIMIT [4] = '{LIMIT_RESET, 25'd40, 25'd200, 25'h0FFFFFF};
    localparam int TX_PCT [4] = '{0, 47, 0, 10};
    localparam int RX_PCT [4] = '{0, 0, 47, 10};

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    in_item_t           s_item;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_item_t          m_item;
    logic               cfg_wr_en;
    logic [COUNT_W-1:0] cfg_wr_data;

    // decoder state
    logic [COUNT_W-1:0]    limit_reg;
    logic [1:0]            parse_ph;
    logic [7:0]            flag_sr;
    logic [3:0]            flags_left;
    logic [7:0]            idx_low;
    logic [7:0]            hist [DEFAULT_WINDOW_DEPTH];
    logic [COUNT_W-1:0]    emitted;
    logic [CONSUMED_W-1:0] consumed;
    out_item_t             decoded_q [$];

    int        tx_idle_pct = 0;
    int        rx_stall_pct = 0;
    logic      squeeze_go = 1'b0;
    logic      hold_off;
    int        quiet = 0;
    int        fault_cnt = 0;
    int        items_sent = 0;
    int        data_seen = 0;
    int        status_seen = 0;
    out_item_t head;

    lzss_window_decompressor_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_stream();
        parse_ph = PH_HEADER;
        flag_sr = '0;
        flags_left = '0;
        idx_low = '0;
        emitted = '0;
        consumed = '0;
        for (int i = 0; i < DEFAULT_WINDOW_DEPTH; i++) hist[i] = 8'h00;
    endfunction

    function automatic void emit_out(input logic [7:0] v);
        out_item_t r;
        emitted = emitted + COUNT_W'(1);
        hist[emitted[TOKEN_INDEX_W-1:0]] = v;
        r = '0;
        r.out_byte = v;
        r.kind = KIND_DATA;
        decoded_q.push_back(r);
    endfunction

    function automatic void advance_flag();
        flag_sr = flag_sr >> 1;
        if (flags_left != 4'd0) flags_left = flags_left - 4'd1;
        parse_ph = (flags_left == 4'd0) ? PH_HEADER : PH_ITEM;
    endfunction

    function automatic void decode_byte(input in_item_t it);
        logic [1:0]               stat;
        logic                     halt;
        logic                     drop_one;
        logic [TOKEN_INDEX_W-1:0] src;
        logic [COPY_LEN_W-1:0]    cnt;
        int                       first;
        out_item_t                r;
        stat = KIND_DATA;
        halt = 1'b0;
        drop_one = 1'b0;
        first = decoded_q.size();
        consumed = consumed + CONSUMED_W'(1);
        case (parse_ph)
            PH_HEADER: begin
                flag_sr = it.data_byte;
                flags_left = 4'd8;
                parse_ph = PH_ITEM;
            end
            PH_ITEM: begin
                if (flag_sr[0]) begin
                    emit_out(it.data_byte);
                    if (emitted > limit_reg) begin
                        halt = 1'b1;
                        stat = KIND_LIMIT;
                    end else begin
                        advance_flag();
                    end
                end else begin
                    idx_low = it.data_byte;
                    parse_ph = PH_CONTROL;
                    drop_one = 1'b1;
                end
            end
            default: begin
                src = {it.data_byte[7:4], idx_low};
                if (src == '0) begin
                    halt = 1'b1;
                    stat = KIND_END;
                end else begin
                    cnt = {1'b0, it.data_byte[3:0]} + COPY_LEN_BIAS;
                    if (emitted > limit_reg || COUNT_W'(cnt) > limit_reg - emitted) begin
                        halt = 1'b1;
                        stat = KIND_LIMIT;
                    end else begin
                        repeat (cnt) begin
                            emit_out(hist[src]);
                            src = src + TOKEN_INDEX_W'(1);
                        end
                        advance_flag();
                    end
                end
            end
        endcase
        if (!halt && it.is_final) begin
            halt = 1'b1;
            stat = KIND_TRUNC;
        end else begin
            drop_one = 1'b0;
        end
        if (halt) begin
            r = '0;
            r.kind = stat;
            r.total_out = emitted;
            r.bytes_consumed = consumed - CONSUMED_W'(drop_one);
            decoded_q.push_back(r);
            clear_stream();
        end
        if (decoded_q.size() > first) begin
            r = decoded_q.pop_back();
            r.run_last = 1'b1;
            decoded_q.push_back(r);
        end
    endfunction

    // steer copy tokens toward written window entries and the end marker
    function automatic in_item_t pick_item();
        in_item_t it;
        it.data_byte = 8'($urandom_range(255));
        it.is_final = ($urandom_range(79) == 0);
        if ($urandom_range(9) == 0) begin
            it.is_final = ($urandom_range(5) == 0);
        end else if (parse_ph == PH_ITEM && !flag_sr[0]) begin
            if ($urandom_range(11) == 0) it.data_byte = 8'h00;
            else if ($urandom_range(3) != 0) it.data_byte = 8'($urandom_range(40, 1));
        end else if (parse_ph == PH_CONTROL && $urandom_range(3) != 0) begin
            it.data_byte[7:4] = 4'h0;
        end
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_byte(it);
        items_sent++;
    endtask

    task automatic write_limit(input logic [COUNT_W-1:0] v);
        s_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        limit_reg = v;
    endtask

    initial begin
        hold_off = 1'b0;
        wait (squeeze_go);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (m_item.kind == KIND_DATA) data_seen++;
            else status_seen++;
            if (decoded_q.size() == 0) begin
                fault_cnt++;
                if (fault_cnt <= 10)
                    $display("unexpected result: byte %h kind %0d last %0b total %0d cons %0d",
                             m_item.out_byte, m_item.kind, m_item.run_last,
                             m_item.total_out, m_item.bytes_consumed);
            end else begin
                head = decoded_q.pop_front();
                if (m_item.out_byte !== head.out_byte || m_item.kind !== head.kind ||
                    m_item.run_last !== head.run_last || m_item.total_out !== head.total_out ||
                    m_item.bytes_consumed !== head.bytes_consumed) begin
                    fault_cnt++;
                    if (fault_cnt <= 10)
                        $display("mismatch: want %h/%0d/%0b/%0d/%0d got %h/%0d/%0b/%0d/%0d",
                                 head.out_byte, head.kind, head.run_last, head.total_out,
                                 head.bytes_consumed, m_item.out_byte, m_item.kind,
                                 m_item.run_last, m_item.total_out, m_item.bytes_consumed);
                end
            end
        end
        m_ready <= !hold_off && ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        limit_reg = LIMIT_RESET;
        clear_stream();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < PLAN_N; i++) begin
            if (PLAN[i].cfg) begin
                write_limit(PLAN[i].lim);
            end else begin
                send_item('{PLAN[i].data, PLAN[i].fin});
                if (PLAN[i].has_want) begin
                    void'(decoded_q.pop_back());
                    decoded_q.push_back(PLAN[i].want);
                end
            end
        end

        for (int p = 0; p < 4; p++) begin
            write_limit(PHASE_LIMIT[p]);
            tx_idle_pct = TX_PCT[p];
            rx_stall_pct = RX_PCT[p];
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 0 && k == 12) squeeze_go = 1'b1;
                send_item(pick_item());
            end
        end

        s_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d compressed bytes, %0d decoded bytes, %0d end/error reports",
                 items_sent, data_seen, status_seen);
        $display("four pacing phases, limits from zero to full scale, one long output hold-off");
        if (fault_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatching results", fault_cnt);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
